// ===== rtl/core/m6502_pkg.sv =====
// ----------------------------------------------------------------------------
// m6502_pkg
// Shared types and constants for the 6502-style execute unit.
// ----------------------------------------------------------------------------
package m6502_pkg;

  typedef enum logic [5:0] {
    OP_AND = 6'd0,  OP_ASL = 6'd1,  OP_BCC = 6'd2,  OP_BCS = 6'd3,
    OP_BEQ = 6'd4,  OP_BIT = 6'd5,  OP_BMI = 6'd6,  OP_BNE = 6'd7,
    OP_BPL = 6'd8,  OP_BRK = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
    OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
    OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
    OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
    OP_INX = 6'd24, OP_INY = 6'd25, OP_LDA = 6'd26, OP_LDX = 6'd27,
    OP_LDY = 6'd28, OP_LSR = 6'd29, OP_NOP = 6'd30, OP_ORA = 6'd31,
    OP_PHA = 6'd32, OP_PHP = 6'd33, OP_PLA = 6'd34, OP_PLP = 6'd35,
    OP_ROL = 6'd36, OP_ROR = 6'd37, OP_SBC = 6'd38, OP_SEC = 6'd39,
    OP_SED = 6'd40, OP_SEI = 6'd41, OP_STA = 6'd42, OP_STX = 6'd43,
    OP_STY = 6'd44, OP_TAX = 6'd45, OP_TAY = 6'd46, OP_TSX = 6'd47,
    OP_TXA = 6'd48, OP_TXS = 6'd49, OP_TYA = 6'd50
  } op_t;

  // Classified operation handed from the front end to the back end.
  typedef struct packed {
    op_t        op;
    logic       known;
    logic       to_acc;
    logic [7:0] operand;
  } uop_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] flags;
    logic [7:0] sp;
    logic       mem_write;
    logic [7:0] write_byte;
    logic       stack_access;
    logic [7:0] stack_slot;
    logic       branch_taken;
  } result_t;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw    = 1;

  localparam logic [7:0] FL_C = 8'h01;
  localparam logic [7:0] FL_Z = 8'h02;
  localparam logic [7:0] FL_I = 8'h04;
  localparam logic [7:0] FL_D = 8'h08;
  localparam logic [7:0] FL_B = 8'h10;
  localparam logic [7:0] FL_U = 8'h20;
  localparam logic [7:0] FL_V = 8'b01000000;
  localparam logic [7:0] FL_N = 8'b10000000;

  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] FLAGS_RESET = 8'h24;

endpackage

// ===== rtl/core/m6502_front.sv =====
// ----------------------------------------------------------------------------
// m6502_front
// Accepts input items, classifies the code and queues them for the back end.
// ----------------------------------------------------------------------------
module m6502_front import m6502_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] in_mode,
  input  logic [7:0] in_operand,
  input  logic       in_to_acc,
  output logic       q_valid,
  input  logic       q_ready,
  output uop_t       q_uop
);

  uop_t                mem_r [FifoDepth];
  logic [FifoAw-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FifoAw:0]     cnt_r, cnt_nxt;
  uop_t                uop;
  logic                push, pop;

  always_comb begin
    uop.op      = op_t'(in_mode);
    uop.known   = (in_mode <= 6'd50);
    uop.to_acc  = in_to_acc;
    uop.operand = in_operand;
  end

  assign in_ready = (cnt_r != (FifoAw+1)'(FifoDepth));
  assign q_valid  = (cnt_r != '0);
  assign q_uop    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (FifoAw+1)'(push) - (FifoAw+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= uop;
    end
  end

endmodule

// ===== rtl/core/m6502_back.sv =====
// ----------------------------------------------------------------------------
// m6502_back
// Holds the register file, executes one operation a cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module m6502_back import m6502_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_ready,
  input  uop_t    q_uop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic [7:0] acc_r, x_r, y_r, sp_r, fl_r;
  logic [7:0] acc_nxt, x_nxt, y_nxt, sp_nxt, fl_nxt;
  logic       vld_r, vld_nxt;
  result_t    res_r, res_nxt;
  logic       fire;
  logic [7:0] m, sh_in, sh_r, nz_v, inv, cmp_reg;
  logic [8:0] sum;
  logic       left, rot, cin, set_nz_en;
  logic       wr, stk, br;
  logic [7:0] wbyte, slot;

  assign q_ready = !vld_r || out_ready;
  assign fire    = q_valid && q_ready;
  assign m       = q_uop.operand;

  always_comb begin
    left    = (q_uop.op == OP_ASL) || (q_uop.op == OP_ROL);
    rot     = (q_uop.op == OP_ROL) || (q_uop.op == OP_ROR);
    cin     = rot && fl_r[0];
    sh_in   = q_uop.to_acc ? acc_r : m;
    sh_r    = left ? {sh_in[6:0], cin} : {cin, sh_in[7:1]};
    inv     = ~m;
    sum     = {1'b0, acc_r} + {1'b0, inv} + {8'd0, fl_r[0]};
    cmp_reg = (q_uop.op == OP_CPX) ? x_r : (q_uop.op == OP_CPY) ? y_r : acc_r;
  end

  always_comb begin
    acc_nxt = acc_r; x_nxt = x_r; y_nxt = y_r; sp_nxt = sp_r; fl_nxt = fl_r;
    wr = 1'b0; stk = 1'b0; br = 1'b0; wbyte = '0; slot = '0;
    nz_v = '0; set_nz_en = 1'b0;
    if (q_uop.known) begin
      unique case (q_uop.op)
        OP_AND: begin acc_nxt = acc_r & m; nz_v = acc_nxt; set_nz_en = 1'b1; end
        OP_ORA: begin acc_nxt = acc_r | m; nz_v = acc_nxt; set_nz_en = 1'b1; end
        OP_EOR: begin acc_nxt = acc_r ^ m; nz_v = acc_nxt; set_nz_en = 1'b1; end
        OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
          fl_nxt[0] = left ? sh_in[7] : sh_in[0];
          nz_v = sh_r; set_nz_en = 1'b1;
          if (q_uop.to_acc) begin
            acc_nxt = sh_r;
          end else begin
            wbyte = sh_r; wr = 1'b1;
          end
        end
        OP_BCC: br = !fl_r[0];
        OP_BCS: br = fl_r[0];
        OP_BEQ: br = fl_r[1];
        OP_BNE: br = !fl_r[1];
        OP_BMI: br = fl_r[7];
        OP_BPL: br = !fl_r[7];
        OP_BVS: br = fl_r[6];
        OP_BVC: br = !fl_r[6];
        OP_BIT: begin
          fl_nxt[1] = ((acc_r & m) == 8'd0);
          fl_nxt[6] = m[6];
          fl_nxt[7] = m[7];
        end
        OP_BRK: fl_nxt = fl_r | FL_B;
        OP_CLC: fl_nxt = fl_r & ~FL_C;
        OP_CLD: fl_nxt = fl_r & ~FL_D;
        OP_CLI: fl_nxt = fl_r & ~FL_I;
        OP_CLV: fl_nxt = fl_r & ~FL_V;
        OP_SEC: fl_nxt = fl_r | FL_C;
        OP_SED: fl_nxt = fl_r | FL_D;
        OP_SEI: fl_nxt = fl_r | FL_I;
        OP_CMP, OP_CPX, OP_CPY: begin
          nz_v = cmp_reg - m; set_nz_en = 1'b1;
          fl_nxt[0] = (cmp_reg >= m);
        end
        OP_DEC: begin wbyte = m - 8'd1; wr = 1'b1; nz_v = wbyte; set_nz_en = 1'b1; end
        OP_INC: begin wbyte = m + 8'd1; wr = 1'b1; nz_v = wbyte; set_nz_en = 1'b1; end
        OP_DEX: begin x_nxt = x_r - 8'd1; nz_v = x_nxt; set_nz_en = 1'b1; end
        OP_DEY: begin y_nxt = y_r - 8'd1; nz_v = y_nxt; set_nz_en = 1'b1; end
        OP_INX: begin x_nxt = x_r + 8'd1; nz_v = x_nxt; set_nz_en = 1'b1; end
        OP_INY: begin y_nxt = y_r + 8'd1; nz_v = y_nxt; set_nz_en = 1'b1; end
        OP_LDA: begin acc_nxt = m; nz_v = m; set_nz_en = 1'b1; end
        OP_LDX: begin x_nxt = m; nz_v = m; set_nz_en = 1'b1; end
        OP_LDY: begin y_nxt = m; nz_v = m; set_nz_en = 1'b1; end
        OP_NOP: ;
        OP_PHA, OP_PHP: begin
          wbyte = (q_uop.op == OP_PHA) ? acc_r : (fl_r | FL_B | FL_U);
          wr = 1'b1; stk = 1'b1; slot = sp_r; sp_nxt = sp_r - 8'd1;
        end
        OP_PLA: begin
          sp_nxt = sp_r + 8'd1; stk = 1'b1; slot = sp_nxt;
          acc_nxt = m; nz_v = m; set_nz_en = 1'b1;
        end
        OP_PLP: begin
          sp_nxt = sp_r + 8'd1; stk = 1'b1; slot = sp_nxt;
          fl_nxt = (m & ~FL_B) | FL_U;
        end
        OP_SBC: begin
          acc_nxt   = sum[7:0];
          fl_nxt[0] = sum[8];
          fl_nxt[6] = (acc_r[7] ^ sum[7]) & (inv[7] ^ sum[7]);
          nz_v = sum[7:0]; set_nz_en = 1'b1;
        end
        OP_STA: begin wbyte = acc_r; wr = 1'b1; end
        OP_STX: begin wbyte = x_r; wr = 1'b1; end
        OP_STY: begin wbyte = y_r; wr = 1'b1; end
        OP_TAX: begin x_nxt = acc_r; nz_v = acc_r; set_nz_en = 1'b1; end
        OP_TAY: begin y_nxt = acc_r; nz_v = acc_r; set_nz_en = 1'b1; end
        OP_TSX: begin x_nxt = sp_r; nz_v = sp_r; set_nz_en = 1'b1; end
        OP_TXA: begin acc_nxt = x_r; nz_v = x_r; set_nz_en = 1'b1; end
        OP_TXS: sp_nxt = x_r;
        OP_TYA: begin acc_nxt = y_r; nz_v = y_r; set_nz_en = 1'b1; end
        default: ;
      endcase
    end
    if (set_nz_en) begin
      fl_nxt[1] = (nz_v == 8'd0);
      fl_nxt[7] = nz_v[7];
    end
    res_nxt.acc          = acc_nxt;
    res_nxt.x            = x_nxt;
    res_nxt.y            = y_nxt;
    res_nxt.flags        = fl_nxt;
    res_nxt.sp           = sp_nxt;
    res_nxt.mem_write    = wr;
    res_nxt.write_byte   = wbyte;
    res_nxt.stack_access = stk;
    res_nxt.stack_slot   = slot;
    res_nxt.branch_taken = br;
    vld_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0; x_r <= '0; y_r <= '0;
      sp_r  <= SP_RESET; fl_r <= FLAGS_RESET;
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (fire) begin
        acc_r <= acc_nxt; x_r <= x_nxt; y_r <= y_nxt;
        sp_r  <= sp_nxt;  fl_r <= fl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/core/mos6502_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mos6502_execute_unit
// Execute stage of a 6502-style processor: register file, ALU and flags.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata fields (low bit up)                      tuser
// in_       slave      mode[5:0] operand[13:6] on_accumulator[14]      -
// out_      master     acc x y flags stack write_byte stack_slot       mem_write
//                      (8 bits each, 56 bits)                          stack_access
//                                                                      branch_taken
// One item per cycle sustained while the output is not stalled; a result
// passes through the front queue, then the back end's output register.
// The register file updates once per item.
// Reset clears the queue and output; A, X, Y = 0, S = 0xFD, P = 0x24.
// A stalled output holds the back end; the two-entry queue absorbs input.
module mos6502_execute_unit import m6502_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // mode, operand, on_accumulator, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // acc, x, y, flags, stack, write_byte, slot
  output logic [2:0]  out_tuser   // mem_write, stack_access, branch_taken
);

  logic    q_valid, q_ready;
  uop_t    q_uop;
  result_t res;

  m6502_front u_front (
    .clk, .rst_n,
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tdata[5:0]),
    .in_operand (in_tdata[13:6]),
    .in_to_acc  (in_tdata[14]),
    .q_valid, .q_ready, .q_uop
  );

  m6502_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_uop,
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.stack_slot, res.write_byte, res.sp, res.flags,
                      res.y, res.x, res.acc};
  assign out_tuser = {res.branch_taken, res.stack_access, res.mem_write};

endmodule

// ===== rtl/core/m6502_checker.sv =====
// ----------------------------------------------------------------------------
// m6502_checker
// Port-level checks on the execute unit.
// ----------------------------------------------------------------------------
module m6502_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The stack slot is only reported with a stack access.
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[55:48] == 8'd0)
    else $error("stack slot without stack access");

  // Write byte is zero without a write.
  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[47:40] == 8'd0)
    else $error("write byte without write");

  // Unused flag bit stays set.
  a_u: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[29])
    else $error("unused flag cleared");

endmodule

bind mos6502_execute_unit m6502_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);
